// ----- rtl/crmn_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the CSR residual max-norm block.
// Used by the channel interfaces, the solution store and the top level.
package crmn_pkg;

  localparam int OPERAND_W = 32;
  localparam int INDEX_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int ACC_W     = 64;
  localparam int NORM_W    = 63;
  localparam int FRAC_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_NONZERO = 2'd1,
    REQ_CLOSE   = 2'd2,
    REQ_FINISH  = 2'd3
  } req_kind_t;

endpackage

// ----- rtl/crmn_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the CSR residual max-norm block.
// Depends on crmn_pkg for field widths.
interface crmn_req_if;
  import crmn_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [INDEX_W-1:0]          column_index;
  logic signed [OPERAND_W-1:0] operand_value;

  modport source (output valid, req_type, column_index, operand_value, input ready);
  modport sink   (input valid, req_type, column_index, operand_value, output ready);
endinterface

interface crmn_res_if;
  import crmn_pkg::*;
  logic              valid;
  logic              ready;
  logic [NORM_W-1:0] residual_norm;
  logic              index_error;

  modport source (output valid, residual_norm, index_error, input ready);
  modport sink   (input valid, residual_norm, index_error, output ready);
endinterface

interface crmn_cfg_if;
  import crmn_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] column_count;

  modport source (output valid, column_count, input ready);
  modport sink   (input valid, column_count, output ready);
endinterface

// ----- rtl/crmn_store.sv -----
`timescale 1ns / 1ps
// Single-port solution vector store with registered read.
// Depends on crmn_pkg for the entry width.
module crmn_store #(
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  we,
  input  logic [$clog2(DEPTH)-1:0]              addr,
  input  logic [crmn_pkg::OPERAND_W-1:0]        wdata,
  output logic [crmn_pkg::OPERAND_W-1:0]        rdata
);
  import crmn_pkg::*;

  logic [OPERAND_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/csr_residual_max_norm.sv -----
`timescale 1ns / 1ps
// Infinity norm of the residual A*x - b over a compressed-row matrix stream.
// A finish transaction passes stages 1 to 4 and then the output register before its result shows.
// Throughput: one transaction per cycle; the pipeline stalls only while a finish in stage 4
// waits on the full output register. The x store needs no clearing pass.
// Reset: accumulator, running maximum, error flag and valids clear; column count 1024.
module csr_residual_max_norm #(
  parameter int VECTOR_DEPTH = 1024
) (
  input logic clk,
  input logic rst,
  crmn_cfg_if.sink   cfg,
  crmn_req_if.sink   req,
  crmn_res_if.source res
);
  import crmn_pkg::*;

  localparam int ADDR_W    = $clog2(VECTOR_DEPTH);
  localparam int IDX_EXT_W = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
  localparam int LIMIT_W   = IDX_EXT_W + 1;
  localparam logic [LIMIT_W-1:0] DEPTH_LIMIT = LIMIT_W'(VECTOR_DEPTH);

  logic [COUNT_W-1:0] column_count;

  // Pipeline control and payload.
  logic                        adv;
  logic                        in_acc;
  req_kind_t                   kind0;
  logic                        idx_ok;
  logic [IDX_EXT_W-1:0]        idx_ext;
  logic                        store_we;
  logic signed [OPERAND_W-1:0] x_rd;

  logic                        s1_valid;
  req_kind_t                   s1_kind;
  logic                        s1_ok;
  logic                        s1_bad;
  logic signed [OPERAND_W-1:0] s1_val;
  logic signed [ACC_W-1:0]     prod;

  logic                        s2_valid;
  req_kind_t                   s2_kind;
  logic                        s2_ok;
  logic                        s2_bad;
  logic signed [OPERAND_W-1:0] s2_val;
  logic signed [ACC_W-1:0]     s2_prod;

  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     sum;
  logic signed [ACC_W-1:0]     sat_sum;
  logic signed [ACC_W-1:0]     rhs;
  logic signed [ACC_W-1:0]     diff;
  logic signed [ACC_W-1:0]     sat_diff;

  logic                        s3_valid;
  req_kind_t                   s3_kind;
  logic                        s3_bad;
  logic signed [ACC_W-1:0]     s3_diff;
  logic [ACC_W-1:0]            mag;

  logic                        s4_valid;
  req_kind_t                   s4_kind;
  logic                        s4_bad;
  logic [ACC_W-1:0]            s4_mag;
  logic                        s4_finish;

  logic [ACC_W-1:0]            running_max;
  logic                        error_seen;
  logic                        res_valid;
  logic [NORM_W-1:0]           res_norm;
  logic                        res_err;

  // Configuration.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= COUNT_RESET;
    end else if (cfg.valid) begin
      column_count <= cfg.column_count;
    end
  end

  // Input decode and store access.
  assign s4_finish = s4_valid && (s4_kind == REQ_FINISH);
  assign adv       = !(s4_finish && res_valid && !res.ready);
  assign req.ready = adv;
  assign in_acc    = req.valid && adv;
  assign kind0     = req_kind_t'(req.req_type);
  assign idx_ext   = IDX_EXT_W'(req.column_index);
  assign idx_ok    = ({1'b0, req.column_index} < column_count)
                  && (LIMIT_W'(idx_ext) < DEPTH_LIMIT);
  assign store_we  = in_acc && (kind0 == REQ_LOAD) && idx_ok;

  crmn_store #(
    .DEPTH (VECTOR_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (adv),
    .we    (store_we),
    .addr  (idx_ext[ADDR_W-1:0]),
    .wdata (req.operand_value),
    .rdata (x_rd)
  );

  // Stage 1: store data arrives, multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind <= kind0;
      s1_ok   <= idx_ok;
      s1_bad  <= !idx_ok && ((kind0 == REQ_LOAD) || (kind0 == REQ_NONZERO));
      s1_val  <= req.operand_value;
    end
  end

  assign prod = s1_val * x_rd;

  // Stage 2: saturating accumulate, or rhs subtraction on row close.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind <= s1_kind;
      s2_ok   <= s1_ok;
      s2_bad  <= s1_bad;
      s2_val  <= s1_val;
      s2_prod <= prod;
    end
  end

  always_comb begin
    sum     = acc + s2_prod;
    sat_sum = sum;
    if ((acc[ACC_W-1] == s2_prod[ACC_W-1]) && (sum[ACC_W-1] != acc[ACC_W-1])) begin
      sat_sum = acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    rhs      = {{(ACC_W-OPERAND_W-FRAC_W){s2_val[OPERAND_W-1]}}, s2_val, {FRAC_W{1'b0}}};
    diff     = acc - rhs;
    sat_diff = diff;
    if ((acc[ACC_W-1] != rhs[ACC_W-1]) && (diff[ACC_W-1] != acc[ACC_W-1])) begin
      sat_diff = acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv && s2_valid) begin
      if ((s2_kind == REQ_NONZERO) && s2_ok) begin
        acc <= sat_sum;
      end else if (s2_kind == REQ_CLOSE) begin
        acc <= '0;
      end
    end
  end

  // Stage 3: absolute value of the row residual.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind <= s2_kind;
      s3_bad  <= s2_bad;
      s3_diff <= sat_diff;
    end
  end

  always_comb begin
    if (s3_diff == ACC_MIN) begin
      mag = ACC_MAX;
    end else if (s3_diff[ACC_W-1]) begin
      mag = -s3_diff;
    end else begin
      mag = s3_diff;
    end
  end

  // Stage 4: running maximum, error flag and finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_kind <= s3_kind;
      s4_bad  <= s3_bad;
      s4_mag  <= mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      error_seen  <= 1'b0;
    end else if (adv && s4_valid) begin
      if (s4_kind == REQ_FINISH) begin
        running_max <= '0;
        error_seen  <= 1'b0;
      end else begin
        if ((s4_kind == REQ_CLOSE) && (s4_mag > running_max)) begin
          running_max <= s4_mag;
        end
        if (s4_bad) begin
          error_seen <= 1'b1;
        end
      end
    end
  end

  // Output register; a held result stalls the pipeline only when another finish arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && s4_finish) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_finish) begin
      res_norm <= running_max[NORM_W-1:0];
      res_err  <= error_seen;
    end
  end

  assign res.valid         = res_valid;
  assign res.residual_norm = res_norm;
  assign res.index_error   = res_err;

endmodule
